FILE: src/xpbe_pkg.sv
// Shared constants and types for the XOR parity block encoder.
package xpbe_pkg;

    localparam int PACKET_BYTES = 1024;
    localparam int WORDS        = PACKET_BYTES / 8;
    localparam int POS_W        = (WORDS > 1) ? $clog2(WORDS) : 1;

    // Result queue: room for the item in the update stage plus one new beat
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic [15:0] BLOCK_SIZE_RESET = 16'd4;

    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t LAST_POS = pos_t'(WORDS - 1);

    typedef struct packed {
        logic [63:0] repair_word;
        logic        header_valid;
        logic [15:0] repair_block;
        logic [15:0] length_parity;
        logic [15:0] repair_length;
        logic [15:0] source_count;
    } result_t;

endpackage

FILE: src/xpbe_out_fifo.sv
// Small result queue between the parity update stage and the m_ channel.
module xpbe_out_fifo (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  xpbe_pkg::result_t               push_data,
    input  logic                            pop_ready,
    output logic                            out_valid,
    output xpbe_pkg::result_t               out_data,
    output logic [xpbe_pkg::OUT_CNT_W-1:0]  count
);

    xpbe_pkg::result_t                 entry_reg [xpbe_pkg::OUT_DEPTH];
    logic [xpbe_pkg::OUT_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [xpbe_pkg::OUT_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [xpbe_pkg::OUT_CNT_W-1:0]    count_reg, count_next;
    logic                              pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/xor_parity_block_encoder.sv
// Top level of the XOR parity block encoder: parity store, update stage, result queue.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------------
//  s_      | in        | s_valid / s_ready   | data_word, symbol_index, block_number, length
//  m_      | out       | m_valid / m_ready   | repair_word, header_valid, header fields
//  cfg_    | in        | cfg_wr_en (no wait) | cfg_wr_data -> block_size
//
//  One beat per cycle sustained while s_ready is high. A beat is read from the
//  one-read-port parity store when taken and written back through the one write port in
//  the next cycle; its result passes the update stage and the result queue before m_.
//  Reset (aresetn low, synchronous) clears word position, length tracking, pipeline and
//  queue; block_size returns to 4. Parity RAM is not cleared.
//  s_ready drops only when the 4-entry result queue could not hold the beat in flight
//  plus a new one, i.e. only after m_ready has been low while results were pushed.
module xor_parity_block_encoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_word,
    input  logic [15:0] s_symbol_index,
    input  logic [15:0] s_block_number,
    input  logic [15:0] s_packet_length,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_repair_word,
    output logic        m_header_valid,
    output logic [15:0] m_repair_block,
    output logic [15:0] m_length_parity,
    output logic [15:0] m_repair_length,
    output logic [15:0] m_source_count
);

    // ---------------------------------------------------------------- config / tracking
    logic [15:0]        block_size_reg;
    xpbe_pkg::pos_t     pos_reg;
    logic [15:0]        length_xor_reg, length_xor_next;
    logic [15:0]        length_max_reg, length_max_next;

    logic               accept;
    logic               in_first;
    logic               in_last_pkt;
    logic               in_last_word;

    // ---------------------------------------------------------------- update stage
    logic               s1_valid_reg;
    xpbe_pkg::pos_t     s1_addr_reg;
    logic [63:0]        s1_word_reg;
    logic               s1_first_reg;
    logic               s1_last_pkt_reg;
    logic               s1_last_word_reg;
    logic [15:0]        s1_block_reg;
    logic               fwd_hit_reg;
    logic [63:0]        fwd_data_reg;
    logic [63:0]        s1_old;
    logic [63:0]        s1_pw;

    // ---------------------------------------------------------------- parity store
    logic [63:0]        parity_mem [xpbe_pkg::WORDS];
    logic [63:0]        rd_data_reg;

    // ---------------------------------------------------------------- result queue
    logic                             push;
    xpbe_pkg::result_t                push_data;
    xpbe_pkg::result_t                out_data;
    logic [xpbe_pkg::OUT_CNT_W-1:0]   out_count;

    // Guarantee queue room for the beat in the update stage and a new one
    assign s_ready = (out_count + xpbe_pkg::OUT_CNT_W'(s1_valid_reg))
                     <= xpbe_pkg::OUT_CNT_W'(xpbe_pkg::OUT_DEPTH - 1);
    assign accept  = s_valid && s_ready;

    assign in_first     = (s_symbol_index == 16'd0);
    assign in_last_pkt  = (s_symbol_index == (block_size_reg - 16'd1));
    assign in_last_word = (pos_reg == xpbe_pkg::LAST_POS);

    // Packet length tracking happens on word 0 of each packet
    always_comb begin
        length_xor_next = length_xor_reg;
        length_max_next = length_max_reg;
        if (accept && (pos_reg == '0)) begin
            if (in_first) begin
                length_xor_next = s_packet_length;
                length_max_next = s_packet_length;
            end else begin
                length_xor_next = length_xor_reg ^ s_packet_length;
                if (s_packet_length > length_max_reg) begin
                    length_max_next = s_packet_length;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= xpbe_pkg::BLOCK_SIZE_RESET;
            pos_reg        <= '0;
            length_xor_reg <= '0;
            length_max_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                block_size_reg <= cfg_wr_data;
            end
            if (accept) begin
                pos_reg <= in_last_word ? '0 : pos_reg + 1'b1;
            end
            length_xor_reg <= length_xor_next;
            length_max_reg <= length_max_next;
            s1_valid_reg   <= accept;
        end
    end

    // Stage payload; forward the word being written now if it is the one we read
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg      <= pos_reg;
            s1_word_reg      <= s_data_word;
            s1_first_reg     <= in_first;
            s1_last_pkt_reg  <= in_last_pkt;
            s1_last_word_reg <= in_last_word;
            s1_block_reg     <= s_block_number;
            fwd_hit_reg      <= s1_valid_reg && (s1_addr_reg == pos_reg);
            fwd_data_reg     <= s1_pw;
        end
    end

    // Read at accept, write back from the update stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= parity_mem[pos_reg];
        end
        if (s1_valid_reg) begin
            parity_mem[s1_addr_reg] <= s1_pw;
        end
    end

    assign s1_old = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign s1_pw  = s1_first_reg ? s1_word_reg : (s1_old ^ s1_word_reg);

    // Results only while the block's last packet streams; header on its final word
    assign push = s1_valid_reg && s1_last_pkt_reg;

    always_comb begin
        push_data               = '0;
        push_data.repair_word   = s1_pw;
        push_data.header_valid  = s1_last_word_reg;
        if (s1_last_word_reg) begin
            push_data.repair_block  = s1_block_reg;
            push_data.length_parity = length_xor_reg;
            push_data.repair_length = length_max_reg;
            push_data.source_count  = block_size_reg;
        end
    end

    xpbe_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .count     (out_count)
    );

    assign m_repair_word   = out_data.repair_word;
    assign m_header_valid  = out_data.header_valid;
    assign m_repair_block  = out_data.repair_block;
    assign m_length_parity = out_data.length_parity;
    assign m_repair_length = out_data.repair_length;
    assign m_source_count  = out_data.source_count;

    // ---------------------------------------------------------------- checks
    // Queue never overflows while the update stage pushes
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (out_count < xpbe_pkg::OUT_CNT_W'(xpbe_pkg::OUT_DEPTH)))
        else $error("result queue overflow");

    // Word position steps once per beat and wraps after the last word
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (pos_reg == ($past(pos_reg) == xpbe_pkg::LAST_POS ? '0
                                : $past(pos_reg) + 1'b1)))
        else $error("word position out of step");

    // Header fields are zero on non-final words
    a_hdr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_header_valid) |-> (m_repair_block == 16'd0 &&
            m_length_parity == 16'd0 && m_repair_length == 16'd0 &&
            m_source_count == 16'd0))
        else $error("header fields set on a non-final word");

    // A result only comes from a beat taken the cycle before
    a_push_src: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> $past(accept))
        else $error("result without a source beat");

endmodule
